// ===== src/dma_arb_pkg.sv =====
package dma_arb_pkg;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_GRANT   = 1'b1
  } dma_arb_op_t;

  typedef enum logic [1:0] {
    REG_ACTIVE_CHANNELS  = 2'd0,
    REG_ROUND_ROBIN_MODE = 2'd1,
    REG_PRIORITY_TABLE   = 2'd2
  } dma_arb_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_DONE
  } dma_arb_state_t;

  typedef struct packed {
    logic       operation;
    logic [3:0] channel;
  } dma_arb_in_t;

  typedef struct packed {
    logic       grant_valid;
    logic [3:0] grant_channel;
    logic       priorities_unique;
  } dma_arb_out_t;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [4:0]  ACTIVE_CHANNELS_RST = 5'd16;
  localparam logic        ROUND_ROBIN_RST     = 1'b0;
  localparam logic [63:0] PRIORITY_TABLE_RST  = 64'hFEDC_BA98_7654_3210;

  function automatic logic [3:0] prio_of(input logic [63:0] table_bits,
                                         input logic [3:0]  ch);
    prio_of = table_bits[{ch, 2'b00} +: 4];
  endfunction

endpackage

// ===== src/dma_channel_arbiter.sv =====
// Sequence per transfer: SCAN scans one channel per cycle over the n effective channels,
//   then DONE shows the result; a round-robin grant first passes through REDUCE, which
//   reduces the start pointer modulo n by repeated subtraction.
// One transfer at a time with busy high: no new transfer is taken until the last is through.
// The result is shown one cycle with done; no stall.
// Reset (rst, synchronous): pending mask and last served cleared, registers to defaults.
module dma_channel_arbiter #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // item interface
  input  logic                                  start,
  output logic                                  busy,
  input  dma_arb_pkg::dma_arb_in_t              item,
  // result interface
  output logic                                  done,
  output dma_arb_pkg::dma_arb_out_t             result,
  // configuration write port
  input  logic                                  cfg_write,
  input  logic [dma_arb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dma_arb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dma_arb_pkg::*;

  // CH_W indexes a channel, CNT_W holds a count up to CHANNELS
  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(CHANNELS + 1);
  localparam logic [4:0]  CH_MAX = 5'(CHANNELS);

  // configuration registers
  logic [4:0]  active_channels;
  logic        round_robin_mode;
  logic [63:0] priority_table;

  // arbitration state
  logic [CHANNELS-1:0] pending_mask;
  logic [CH_W-1:0]     last_served;

  // sequencer and working registers for the current transfer
  dma_arb_state_t state, state_next;
  logic            op;
  logic [3:0]      req_ch;
  logic [CNT_W-1:0] cnt;      // uniqueness / fixed-priority scan index
  logic [CNT_W-1:0] ptr;      // round-robin scan pointer
  logic [15:0]     seen;      // priorities seen so far
  logic            uniq,  uniq_next;
  logic            valid, valid_next;
  logic [CH_W-1:0] sel,   sel_next;
  logic [3:0]      best,  best_next;
  logic [15:0]     seen_next;

  // effective count: active_channels clamped to 1..CHANNELS
  logic [4:0]       n_clamp;
  logic [CNT_W-1:0] n_eff;

  always_comb begin
    priority if (active_channels == 5'd0) begin
      n_clamp = 5'd1;
    end else if (active_channels > CH_MAX) begin
      n_clamp = CH_MAX;
    end else begin
      n_clamp = active_channels;
    end
    n_eff = n_clamp[CNT_W-1:0];
  end

  // one channel per cycle: priority lookup, seen check, pending test, compare
  logic [CH_W-1:0]  scan_ch;
  logic [CH_W-1:0]  cand_ch;
  logic [3:0]       cur_prio;
  logic             last_step;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] ptr_inc;

  assign scan_ch   = cnt[CH_W-1:0];
  assign cand_ch   = round_robin_mode ? ptr[CH_W-1:0] : scan_ch;
  assign cur_prio  = prio_of(priority_table, 4'(scan_ch));
  assign cnt_inc   = CNT_W'(cnt + 1'b1);
  assign ptr_inc   = CNT_W'(ptr + 1'b1);
  assign last_step = (cnt_inc == n_eff);

  always_comb begin
    uniq_next  = uniq & ~seen[cur_prio];
    seen_next  = seen | (16'd1 << cur_prio);
    valid_next = valid;
    sel_next   = sel;
    best_next  = best;
    if (op == OP_GRANT && pending_mask[cand_ch]) begin
      if (round_robin_mode) begin
        // first pending channel after last served wins
        if (!valid) begin
          valid_next = 1'b1;
          sel_next   = cand_ch;
        end
      end else if (!valid || cur_prio > best) begin
        // strictly higher priority only, so ties keep the lower index
        valid_next = 1'b1;
        sel_next   = cand_ch;
        best_next  = cur_prio;
      end
    end
  end

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (item.operation == OP_GRANT && round_robin_mode) ? ST_REDUCE
                                                                        : ST_SCAN;
        end
      end
      ST_REDUCE: begin
        if (ptr < n_eff) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
  end

  assign result.grant_valid       = valid;
  assign result.grant_channel     = 4'(sel);
  assign result.priorities_unique = uniq;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers; to be written only while idle, which the user must ensure (the block does not enforce it)
  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels  <= ACTIVE_CHANNELS_RST;
      round_robin_mode <= ROUND_ROBIN_RST;
      priority_table   <= PRIORITY_TABLE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ACTIVE_CHANNELS:  active_channels  <= cfg_data[4:0];
        REG_ROUND_ROBIN_MODE: round_robin_mode <= cfg_data[0];
        REG_PRIORITY_TABLE:   priority_table   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pending mask and last served: updated once, when the result goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_mask <= '0;
      last_served  <= '0;
    end else if (state == ST_DONE) begin
      if (op == OP_REQUEST) begin
        if ({1'b0, req_ch} < n_clamp) begin
          pending_mask[req_ch[CH_W-1:0]] <= 1'b1;
        end
      end else if (valid) begin
        pending_mask[sel] <= 1'b0;
        last_served       <= sel;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op     <= item.operation;
          req_ch <= item.channel;
          cnt    <= '0;
          ptr    <= CNT_W'(last_served + 1'b1);
          seen   <= '0;
          uniq   <= 1'b1;
          valid  <= 1'b0;
          sel    <= '0;
          best   <= '0;
        end
      end
      ST_REDUCE: begin
        // (last_served + 1) mod n by repeated subtraction
        if (ptr >= n_eff) begin
          ptr <= CNT_W'(ptr - n_eff);
        end
      end
      ST_SCAN: begin
        cnt   <= cnt_inc;
        ptr   <= (ptr_inc == n_eff) ? '0 : ptr_inc;
        seen  <= seen_next;
        uniq  <= uniq_next;
        valid <= valid_next;
        sel   <= sel_next;
        best  <= best_next;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // checks
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result transfer outside a busy period");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
      (done && !result.grant_valid) |-> (result.grant_channel == 4'd0))
    else $error("grant channel nonzero without a grant");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import dma_arb_pkg::*;

  // Index 3 of the register port decodes to nothing; writes there must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Watchdog limit, set to leave several times the slowest correct run of
  // all transfers with their sender gaps.
  localparam int unsigned CYCLE_LIMIT = 600_000;
  // Settle time at the end, once the block is idle.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned PHASES = 12;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  dma_arb_in_t item;
  logic done;
  dma_arb_out_t result;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dma_channel_arbiter #(
    .CHANNELS(16)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Free-running clock, period 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ------------------------------------------------------------------
  // Shadow copy of the arbiter: registers and arbitration state.
  // ------------------------------------------------------------------
  logic [4:0]  shadow_active;
  logic        shadow_rr;
  logic [63:0] shadow_prio_map;
  logic [15:0] shadow_pending;
  logic [3:0]  shadow_last;

  // Results still owed by the block, one per transfer, oldest first.
  dma_arb_out_t expected_grants[$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned grants_made;
  int unsigned grants_empty;
  int unsigned configs_applied;

  // Channel count as the block uses it: 0 acts as 1, anything over 16 as 16.
  function automatic int unsigned channel_count();
    if (shadow_active == 5'd0) begin
      return 1;
    end
    if (shadow_active > 5'd16) begin
      return 16;
    end
    return 32'(shadow_active);
  endfunction

  function automatic logic [3:0] prio_nibble(input int unsigned ch);
    return shadow_prio_map[ch*4 +: 4];
  endfunction

  // Applies one transfer to the shadow state and returns the result it owes.
  function automatic dma_arb_out_t predict_arbitration(input dma_arb_in_t req);
    int unsigned n;
    int unsigned c;
    int unsigned step;
    logic        found;
    logic [3:0]  sel;
    logic [3:0]  best;
    logic [15:0] seen;
    dma_arb_out_t r;
    n = channel_count();
    found = 1'b0;
    sel = 4'd0;
    best = 4'd0;
    if (req.operation == OP_REQUEST) begin
      // Requests for channels at or above the count are dropped.
      if (req.channel < n) begin
        shadow_pending[req.channel] = 1'b1;
      end
    end else if (shadow_rr) begin
      // Scan starts one past the last served channel, wrapping at the count,
      // even when last served sits above the current count.
      for (step = 1; step <= n; step++) begin
        c = (shadow_last + step) % n;
        if (!found && shadow_pending[c]) begin
          found = 1'b1;
          sel = c[3:0];
        end
      end
    end else begin
      // Strict compare keeps the lowest index on a priority tie.
      for (c = 0; c < n; c++) begin
        if (shadow_pending[c] && (!found || prio_nibble(c) > best)) begin
          found = 1'b1;
          sel = c[3:0];
          best = prio_nibble(c);
        end
      end
    end
    if (found) begin
      shadow_pending[sel] = 1'b0;
      shadow_last = sel;
    end
    r.grant_valid = found;
    r.grant_channel = sel;
    r.priorities_unique = 1'b1;
    seen = 16'd0;
    for (c = 0; c < n; c++) begin
      if (seen[prio_nibble(c)]) begin
        r.priorities_unique = 1'b0;
      end
      seen[prio_nibble(c)] = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("MISMATCH @%0t cycle %0d: %s got %0d expected %0d",
             $time, cycle_count, what, got, want);
  endtask

  // ------------------------------------------------------------------
  // Result checker: every done strobe is one transfer, matched in order.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    dma_arb_out_t want;
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (expected_grants.size() == 0) begin
        report_mismatch("result with nothing outstanding, grant_channel",
                        result.grant_channel, 0);
      end else begin
        want = expected_grants.pop_front();
        if (result.grant_valid !== want.grant_valid) begin
          report_mismatch("grant_valid", result.grant_valid, want.grant_valid);
        end
        if (result.grant_channel !== want.grant_channel) begin
          report_mismatch("grant_channel", result.grant_channel, want.grant_channel);
        end
        if (result.priorities_unique !== want.priorities_unique) begin
          report_mismatch("priorities_unique", result.priorities_unique,
                          want.priorities_unique);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_grants.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Driver tasks. All drive happens with NBAs right after a rising edge.
  // ------------------------------------------------------------------

  // Presents one transfer and holds it until accepted (start high, busy low).
  // start is left high afterwards so back-to-back transfers need no toggle;
  // a nonzero gap drops it and waits out the gap before the task returns.
  task automatic send_item(input dma_arb_op_t op, input logic [3:0] ch,
                           input int unsigned gap);
    dma_arb_in_t req;
    dma_arb_out_t want;
    req.operation = op;
    req.channel = ch;
    start <= 1'b1;
    item <= req;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    want = predict_arbitration(req);
    expected_grants.push_back(want);
    items_sent++;
    if (op == OP_GRANT) begin
      if (want.grant_valid) begin
        grants_made++;
      end else begin
        grants_empty++;
      end
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops start and waits until every owed result is in and the block is idle.
  task automatic wait_idle();
    start <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_grants.size() != 0 || busy !== 1'b0);
  endtask

  // One register write per edge; upper bits of the small registers carry noise.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_ACTIVE_CHANNELS: shadow_active = value[4:0];
      REG_ROUND_ROBIN_MODE: shadow_rr = value[0];
      REG_PRIORITY_TABLE: shadow_prio_map = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [4:0] active, input logic rr,
                           input logic [63:0] prio_map);
    logic [63:0] noise;
    wait_idle();
    noise = {$urandom, $urandom};
    write_reg(REG_ACTIVE_CHANNELS, {noise[63:5], active});
    noise = {$urandom, $urandom};
    write_reg(REG_ROUND_ROBIN_MODE, {noise[63:1], rr});
    write_reg(REG_PRIORITY_TABLE, prio_map);
    cfg_write <= 1'b0;
    configs_applied++;
  endtask

  // Random table, a permutation of 0..15, or a two-level table full of ties.
  function automatic logic [63:0] random_prio_map();
    logic [3:0] perm[16];
    logic [3:0] tmp;
    logic [63:0] m;
    int unsigned j;
    int unsigned i;
    case ($urandom_range(2))
      0: m = {$urandom, $urandom};
      1: begin
        for (i = 0; i < 16; i++) begin
          perm[i] = i[3:0];
        end
        for (i = 15; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (i = 0; i < 16; i++) begin
          m[i*4 +: 4] = perm[i];
        end
      end
      default: begin
        for (i = 0; i < 16; i++) begin
          m[i*4 +: 4] = $urandom_range(1) ? 4'hF : 4'h0;
        end
      end
    endcase
    return m;
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Out of reset: 16 channels, fixed mode, priority equals channel index.
  task automatic test_reset_defaults();
    send_item(OP_REQUEST, 4'd0, 0);
    send_item(OP_REQUEST, 4'd15, 0);
    send_item(OP_GRANT, 4'd15, 0);   // channel 15 holds the top priority
    send_item(OP_GRANT, 4'd0, 0);
    send_item(OP_GRANT, 4'd9, 0);    // nothing pending
  endtask

  // All priorities equal: the lower index must win the tie.
  task automatic test_fixed_ties();
    configure(5'd16, 1'b0, 64'd0);
    send_item(OP_REQUEST, 4'd7, 0);
    send_item(OP_REQUEST, 4'd3, 0);
    send_item(OP_GRANT, 4'd0, 0);
    send_item(OP_GRANT, 4'd0, 0);
  endtask

  // Round-robin with last served (7) above a count of 4: scan wraps from 0.
  task automatic test_round_robin();
    configure(5'd4, 1'b1, random_prio_map());
    send_item(OP_REQUEST, 4'd0, 0);
    send_item(OP_REQUEST, 4'd1, 0);
    send_item(OP_REQUEST, 4'd3, 0);
    send_item(OP_GRANT, 4'd0, 0);
    send_item(OP_GRANT, 4'd0, 0);
    send_item(OP_GRANT, 4'd0, 0);
  endtask

  // Count clamping, inactive requests, stale pending bits above the count,
  // and a write to the unused register index.
  task automatic test_channel_count();
    configure(5'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_REQUEST, 4'd5, 0);  // dropped, only channel 0 active
    send_item(OP_REQUEST, 4'd0, 0);
    send_item(OP_GRANT, 4'd0, 0);
    configure(5'd16, 1'b0, PRIORITY_TABLE_RST);
    send_item(OP_REQUEST, 4'd12, 0);
    configure(5'd2, 1'b0, PRIORITY_TABLE_RST);
    send_item(OP_GRANT, 4'd0, 0);    // bit 12 stays but is out of reach
    wait_idle();
    write_reg(REG_UNUSED, {$urandom, $urandom});
    cfg_write <= 1'b0;
    configure(5'd31, 1'b0, PRIORITY_TABLE_RST);
    send_item(OP_GRANT, 4'd0, 0);    // count back to 16, bit 12 granted
  endtask

  // Random traffic over a series of settings and sender idle rates.
  task automatic test_random_traffic();
    int unsigned p;
    int unsigned i;
    int unsigned n;
    int unsigned idle_pct;
    int unsigned gap;
    logic [4:0] active;
    logic rr;
    dma_arb_op_t op;
    logic [3:0] ch;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin active = 5'd16; rr = 1'b0; end
        1: begin active = 5'd1;  rr = 1'b1; end
        2: begin active = 5'd16; rr = 1'b1; end
        3: begin active = 5'd1;  rr = 1'b0; end
        4: begin active = 5'($urandom_range(31)); rr = 1'($urandom_range(1)); end
        default: begin
          active = 5'($urandom_range(2, 16));
          rr = 1'($urandom_range(1));
        end
      endcase
      configure(active, rr, random_prio_map());
      n = channel_count();
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 69;
        default: idle_pct = 16;
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // Slightly request-heavy so several channels compete per grant.
        op = ($urandom_range(99) < 42) ? OP_GRANT : OP_REQUEST;
        // Mostly active channels; the rest exercise the ignored requests.
        ch = ($urandom_range(99) < 80) ? 4'($urandom_range(n - 1)) : 4'($urandom_range(15));
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 40) : 0;
        send_item(op, ch, gap);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    shadow_active = ACTIVE_CHANNELS_RST;
    shadow_rr = ROUND_ROBIN_RST;
    shadow_prio_map = PRIORITY_TABLE_RST;
    shadow_pending = 16'd0;
    shadow_last = 4'd0;
    items_sent = 0;
    grants_made = 0;
    grants_empty = 0;
    configs_applied = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_fixed_ties();
    test_round_robin();
    test_channel_count();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d transfers (%0d results) across %0d register settings in %0d cycles",
             items_sent, results_seen, configs_applied, cycle_count);
    $display("Grants issued: %0d, grants with nothing pending: %0d",
             grants_made, grants_empty);
    if (mismatch_count == 0 && expected_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
